// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console cell writer.
// No dependencies; every file but tcw_checker imports this package.
package tcw_pkg;

   // One stored cell: glyph byte, attribute bits, ARGB colors.
   typedef struct packed {
      logic [7:0]  glyph;
      logic [3:0]  attr;
      logic [31:0] fg;
      logic [31:0] bg;
   } tcw_cell_type;

   // Configuration register file as seen by the controller.
   typedef struct packed {
      logic [7:0]  column_count;
      logic [5:0]  row_count;
      logic [31:0] write_fg;
      logic [31:0] write_bg;
      logic [3:0]  write_attr;
      logic [31:0] blank_fg;
      logic [31:0] blank_bg;
   } tcw_cfg_type;

   typedef enum logic [2:0] {
      CSR_COLUMN_COUNT = 3'd0,
      CSR_ROW_COUNT    = 3'd1,
      CSR_WRITE_FG     = 3'd2,
      CSR_WRITE_BG     = 3'd3,
      CSR_WRITE_ATTR   = 3'd4,
      CSR_BLANK_FG     = 3'd5,
      CSR_BLANK_BG     = 3'd6,
      CSR_UNUSED       = 3'd7
   } tcw_csr_type;

   localparam logic [7:0]  KEY_BACKSPACE = 8'h2A;
   localparam logic [7:0]  KEY_ENTER     = 8'h28;
   localparam logic [7:0]  CHAR_CR       = 8'd13;
   localparam logic [7:0]  CHAR_LF       = 8'd10;
   localparam logic [7:0]  CHAR_TAB      = 8'd9;
   localparam logic [7:0]  CHAR_SPACE    = 8'd32;
   localparam logic [7:0]  PRINT_LOW     = 8'd32;
   localparam logic [7:0]  PRINT_HIGH    = 8'd126;
   localparam int          TAB_STEP      = 8;

   localparam logic [31:0] RESET_FG      = 32'hFFE0E0E0;
   localparam logic [31:0] RESET_BG      = 32'hFF1E1E1E;
   localparam logic [7:0]  RESET_COLUMNS = 8'd80;
   localparam logic [5:0]  RESET_ROWS    = 6'd25;

   localparam tcw_cell_type RESET_CELL = '{
      glyph: CHAR_SPACE, attr: 4'd0, fg: RESET_FG, bg: RESET_BG
   };

endpackage

// File: rtl/tcw_cell_ram.sv
`timescale 1ns / 1ps
// Cell grid storage: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell type.
module tcw_cell_ram #(
   parameter int AW = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  tcw_pkg::tcw_cell_type wr_data,
   input  logic [AW-1:0]        rd_addr,
   output tcw_pkg::tcw_cell_type rd_data
);
   import tcw_pkg::*;

   tcw_cell_type mem [2**AW];
   tcw_cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tcw_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: cursor, byte handling, scroll and clear sweeps over the cell RAM.
// Depends on tcw_pkg; drives the ports of tcw_cell_ram.
module tcw_ctrl #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tcw_pkg::tcw_cfg_type  cfg,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_mode,
   input  logic [7:0]            req_char_code,
   input  logic [7:0]            req_key_code,
   input  logic [4:0]            req_read_row,
   input  logic [6:0]            req_read_col,
   output logic                  rsp_valid,
   output logic [6:0]            rsp_cursor_column,
   output logic [4:0]            rsp_cursor_line,
   output logic                  rsp_scrolled,
   output logic                  rsp_redraw_needed,
   output logic [7:0]            rsp_cell_char,
   output logic [31:0]           rsp_cell_fg,
   output logic [31:0]           rsp_cell_bg,
   output logic [3:0]            rsp_cell_attributes,
   output logic                  ram_we,
   output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] ram_waddr,
   output tcw_pkg::tcw_cell_type ram_wdata,
   output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLUMNS)-1:0] ram_raddr,
   input  tcw_pkg::tcw_cell_type ram_rdata
);
   import tcw_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int AW = CW + RW;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_EXEC, S_READ, S_SCROLL, S_DRAIN, S_BLANK, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE, OP_PUT, OP_BS, OP_ENTER, OP_READ
   } op_type;

   state_type    state_ff, state_in;
   op_type       op_ff, op_in;
   logic [7:0]   byte_ff, byte_in;
   logic         post_dec_ff, post_dec_in;
   logic         redraw_ff, redraw_in;
   logic         scrolled_ff, scrolled_in;
   logic         in_range_ff, in_range_in;
   logic [AW-1:0] rd_addr_ff, rd_addr_in;
   tcw_cell_type cell_ff, cell_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] sx_ff, sx_in;
   logic [RW-1:0] sy_ff, sy_in;
   logic         pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [6:0]   rsp_col_ff, rsp_col_in;
   logic [4:0]   rsp_line_ff, rsp_line_in;
   logic         rsp_scrolled_ff, rsp_scrolled_in;
   logic         rsp_redraw_ff, rsp_redraw_in;
   tcw_cell_type rsp_cell_ff, rsp_cell_in;

   logic [CW:0]  cols_used;
   logic [RW:0]  rows_used;
   logic [RW:0]  rows_m1;
   logic [CW:0]  col_p1;
   logic [CW:0]  tab_sum;
   logic [RW:0]  row_p1;
   logic         nl_wrap;
   logic         in_area;
   logic         last_col;
   logic         last_row;
   logic         do_nl;
   logic [CW-1:0] col_fin;

   // Clamp the configured size into 1..MAX.
   always_comb begin
      priority if (cfg.column_count == 8'd0) begin
         cols_used = (CW+1)'(1);
      end else if (32'(cfg.column_count) > 32'(MAX_COLUMNS)) begin
         cols_used = (CW+1)'(MAX_COLUMNS);
      end else begin
         cols_used = (CW+1)'(cfg.column_count);
      end
      priority if (cfg.row_count == 6'd0) begin
         rows_used = (RW+1)'(1);
      end else if (32'(cfg.row_count) > 32'(MAX_ROWS)) begin
         rows_used = (RW+1)'(MAX_ROWS);
      end else begin
         rows_used = (RW+1)'(cfg.row_count);
      end
   end

   assign rows_m1  = rows_used - 1'b1;
   assign col_p1   = {1'b0, col_ff} + 1'b1;
   assign tab_sum  = ({1'b0, col_ff} + (CW+1)'(TAB_STEP)) & ~(CW+1)'(TAB_STEP - 1);
   assign row_p1   = {1'b0, row_ff} + 1'b1;
   assign nl_wrap  = row_p1 >= rows_used;
   assign in_area  = ({1'b0, col_ff} < cols_used) && ({1'b0, row_ff} < rows_used);
   assign last_col = ({1'b0, sx_ff} + 1'b1) == cols_used;
   assign last_row = ((RW+1)'(sy_ff) + (RW+1)'(2)) == rows_used;
   assign col_fin  = (post_dec_ff && (col_ff != '0)) ? col_ff - 1'b1 : col_ff;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      byte_in         = byte_ff;
      post_dec_in     = post_dec_ff;
      redraw_in       = redraw_ff;
      scrolled_in     = scrolled_ff;
      in_range_in     = in_range_ff;
      rd_addr_in      = rd_addr_ff;
      cell_in         = cell_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      sx_in           = sx_ff;
      sy_in           = sy_ff;
      pend_in         = 1'b0;
      pend_addr_in    = pend_addr_ff;
      clr_in          = clr_ff;
      rsp_valid_in    = 1'b0;
      rsp_col_in      = rsp_col_ff;
      rsp_line_in     = rsp_line_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_redraw_in   = rsp_redraw_ff;
      rsp_cell_in     = rsp_cell_ff;
      ram_we          = 1'b0;
      ram_waddr       = {row_ff, col_ff};
      ram_wdata       = '{glyph: byte_ff, attr: cfg.write_attr,
                          fg: cfg.write_fg, bg: cfg.write_bg};
      ram_raddr       = rd_addr_ff;
      do_nl           = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = RESET_CELL;
            clr_in    = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               state_in    = S_EXEC;
               byte_in     = req_char_code;
               post_dec_in = 1'b0;
               scrolled_in = 1'b0;
               redraw_in   = 1'b0;
               cell_in     = '0;
               rd_addr_in  = {RW'(req_read_row), CW'(req_read_col)};
               in_range_in = (32'(req_read_row) < 32'(MAX_ROWS)) &&
                             (32'(req_read_col) < 32'(MAX_COLUMNS));
               op_in       = OP_NONE;
               unique case (req_mode)
                  2'd0: op_in = OP_PUT;
                  2'd1: begin
                     priority if (req_key_code == KEY_BACKSPACE) begin
                        op_in     = OP_BS;
                        redraw_in = 1'b1;
                     end else if (req_key_code == KEY_ENTER) begin
                        op_in     = OP_ENTER;
                        redraw_in = 1'b1;
                     end else if (req_char_code >= PRINT_LOW &&
                                  req_char_code <= PRINT_HIGH) begin
                        op_in     = OP_PUT;
                        redraw_in = 1'b1;
                     end else begin
                        op_in     = OP_NONE;
                     end
                  end
                  2'd2: op_in = OP_READ;
                  default: op_in = OP_NONE;
               endcase
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_PUT: begin
                  priority if (byte_ff == CHAR_CR) begin
                     col_in   = '0;
                     state_in = S_DONE;
                  end else if (byte_ff == CHAR_LF) begin
                     do_nl = 1'b1;
                  end else if (byte_ff == CHAR_TAB) begin
                     if (tab_sum >= cols_used) begin
                        col_in = '0;
                        do_nl  = 1'b1;
                     end else begin
                        col_in   = tab_sum[CW-1:0];
                        state_in = S_DONE;
                     end
                  end else if (in_area) begin
                     ram_we = 1'b1;
                     if (col_p1 >= cols_used) begin
                        col_in = '0;
                        do_nl  = 1'b1;
                     end else begin
                        col_in   = col_p1[CW-1:0];
                        state_in = S_DONE;
                     end
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_BS: begin
                  // Step back, then erase with a space through the normal put path.
                  if (col_ff != '0) begin
                     col_in      = col_ff - 1'b1;
                     op_in       = OP_PUT;
                     byte_in     = CHAR_SPACE;
                     post_dec_in = 1'b1;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               OP_ENTER: begin
                  col_in = '0;
                  do_nl  = 1'b1;
               end
               OP_READ: state_in = S_READ;
               default: state_in = S_DONE;
            endcase
            if (do_nl) begin
               if (nl_wrap) begin
                  row_in      = rows_m1[RW-1:0];
                  scrolled_in = 1'b1;
                  sx_in       = '0;
                  sy_in       = '0;
                  state_in    = (rows_used == (RW+1)'(1)) ? S_BLANK : S_SCROLL;
               end else begin
                  row_in   = row_p1[RW-1:0];
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            if (in_range_ff) begin
               cell_in = ram_rdata;
            end
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // Read the row below, write it back one row up in the cycle after.
            ram_raddr    = {sy_ff + 1'b1, sx_ff};
            pend_in      = 1'b1;
            pend_addr_in = {sy_ff, sx_ff};
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = pend_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (last_col) begin
               sx_in = '0;
               sy_in = sy_ff + 1'b1;
               if (last_row) begin
                  state_in = S_DRAIN;
               end
            end else begin
               sx_in = sx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            ram_we    = pend_ff;
            ram_waddr = pend_addr_ff;
            ram_wdata = ram_rdata;
            sx_in     = '0;
            state_in  = S_BLANK;
         end
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = {rows_m1[RW-1:0], sx_ff};
            ram_wdata = '{glyph: CHAR_SPACE, attr: 4'd0,
                          fg: cfg.blank_fg, bg: cfg.blank_bg};
            if (last_col) begin
               state_in = S_DONE;
            end else begin
               sx_in = sx_ff + 1'b1;
            end
         end
         S_DONE: begin
            col_in          = col_fin;
            rsp_valid_in    = 1'b1;
            rsp_col_in      = 7'(col_fin);
            rsp_line_in     = 5'(row_ff);
            rsp_scrolled_in = scrolled_ff;
            rsp_redraw_in   = redraw_ff;
            rsp_cell_in     = cell_ff;
            state_in        = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      byte_ff         <= byte_in;
      post_dec_ff     <= post_dec_in;
      redraw_ff       <= redraw_in;
      scrolled_ff     <= scrolled_in;
      in_range_ff     <= in_range_in;
      rd_addr_ff      <= rd_addr_in;
      cell_ff         <= cell_in;
      sx_ff           <= sx_in;
      sy_ff           <= sy_in;
      pend_addr_ff    <= pend_addr_in;
      rsp_col_ff      <= rsp_col_in;
      rsp_line_ff     <= rsp_line_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
      rsp_redraw_ff   <= rsp_redraw_in;
      rsp_cell_ff     <= rsp_cell_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy                = state_ff != S_IDLE;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_line     = rsp_line_ff;
   assign rsp_scrolled        = rsp_scrolled_ff;
   assign rsp_redraw_needed   = rsp_redraw_ff;
   assign rsp_cell_char       = rsp_cell_ff.glyph;
   assign rsp_cell_fg         = rsp_cell_ff.fg;
   assign rsp_cell_bg         = rsp_cell_ff.bg;
   assign rsp_cell_attributes = rsp_cell_ff.attr;

endmodule

// File: rtl/text_console_cell_writer.sv
`timescale 1ns / 1ps
// Channel   Ports                         Transfer
// request   start/busy, req_*             start high and busy low at a clock edge
// result    rsp_valid, rsp_*              rsp_valid high for one cycle, never held off
// config    csr_write_enable, csr_*       write enable high at a clock edge
//
// Plain byte, CR, LF, tab, enter or ignored item: the controller steps through S_EXEC and
// S_DONE, then registers the result strobe; a backspace off column 0 runs S_EXEC twice and
// a read adds S_READ. A line feed past the last row adds a scroll that moves each row up
// one and then blanks the last row (only the blank with a single row), all on the single
// RAM write port. After reset, busy stays high while every cell (MAX_ROWS*MAX_COLUMNS,
// power-of-two rounded) is cleared. Results cannot be stalled.
// Depends on tcw_pkg, tcw_ctrl and tcw_cell_ram.
module text_console_cell_writer #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_ROWS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_key_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_line,
   output logic        rsp_scrolled,
   output logic        rsp_redraw_needed,
   output logic [7:0]  rsp_cell_char,
   output logic [31:0] rsp_cell_fg,
   output logic [31:0] rsp_cell_bg,
   output logic [3:0]  rsp_cell_attributes,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import tcw_pkg::*;

   localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLUMNS);

   tcw_cfg_type  cfg_ff;
   logic         ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   tcw_cell_type ram_wdata;
   tcw_cell_type ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.column_count <= RESET_COLUMNS;
         cfg_ff.row_count    <= RESET_ROWS;
         cfg_ff.write_fg     <= RESET_FG;
         cfg_ff.write_bg     <= RESET_BG;
         cfg_ff.write_attr   <= 4'd0;
         cfg_ff.blank_fg     <= RESET_FG;
         cfg_ff.blank_bg     <= RESET_BG;
      end else if (csr_write_enable) begin
         unique case (tcw_csr_type'(csr_index))
            CSR_COLUMN_COUNT: cfg_ff.column_count <= csr_write_data[7:0];
            CSR_ROW_COUNT:    cfg_ff.row_count    <= csr_write_data[5:0];
            CSR_WRITE_FG:     cfg_ff.write_fg     <= csr_write_data;
            CSR_WRITE_BG:     cfg_ff.write_bg     <= csr_write_data;
            CSR_WRITE_ATTR:   cfg_ff.write_attr   <= csr_write_data[3:0];
            CSR_BLANK_FG:     cfg_ff.blank_fg     <= csr_write_data;
            CSR_BLANK_BG:     cfg_ff.blank_bg     <= csr_write_data;
            default: ;
         endcase
      end
   end

   tcw_ctrl #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_ROWS   (MAX_ROWS)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_key_code       (req_key_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cursor_line    (rsp_cursor_line),
      .rsp_scrolled       (rsp_scrolled),
      .rsp_redraw_needed  (rsp_redraw_needed),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_fg        (rsp_cell_fg),
      .rsp_cell_bg        (rsp_cell_bg),
      .rsp_cell_attributes(rsp_cell_attributes),
      .ram_we             (ram_we),
      .ram_waddr          (ram_waddr),
      .ram_wdata          (ram_wdata),
      .ram_raddr          (ram_raddr),
      .ram_rdata          (ram_rdata)
   );

   tcw_cell_ram #(
      .AW(AW)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

endmodule

// File: rtl/tcw_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the command and result timing of the console writer.
// Bound to text_console_cell_writer; no package dependency.
module tcw_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // Every item keeps busy high through at least an execute and a done step, so strobes never touch.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after a request transfer");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_strobe_follows_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

endmodule

bind text_console_cell_writer tcw_checker u_tcw_checker (.*);
